>>> hdl/assert_macros.svh
// Assertion macros used by the checker file.
// Every macro samples on clk; CFBR_ASSERT also uses rst_n from the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define CFBR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define CFBR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> hdl/cfbr_pkg.sv
// ----------------------------------------------------------------------------
// cfbr_pkg
// Types, constants and the ones-complement adder of the frame byte receiver.
// ----------------------------------------------------------------------------
package cfbr_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned POS_W    = 14;
  localparam int unsigned BODY_W   = 13;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned SUM_W    = 16;
  localparam int unsigned CFG_IDX_W = 1;

  // byte_out, byte_position, body_bytes, status packed and padded to bytes
  localparam int unsigned RES_BITS = BYTE_W + POS_W + BODY_W + STATUS_W;
  localparam int unsigned OUT_DATA_W = ((RES_BITS + 7) / 8) * 8;

  localparam int unsigned POS_LSB    = BYTE_W;
  localparam int unsigned BODY_LSB   = POS_LSB + POS_W;
  localparam int unsigned STATUS_LSB = BODY_LSB + BODY_W;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_START_BYTE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ADDR = 1'd1;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_IN_FRAME = 2'd0;
  localparam logic [STATUS_W-1:0] ST_REJECTED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_GOOD     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BAD      = 2'd3;

  localparam logic [POS_W-1:0]  POS_FIRST     = 14'd0;
  localparam logic [POS_W-1:0]  POS_ADDR      = 14'd1;
  localparam logic [POS_W-1:0]  POS_LEN_LOW   = 14'd2;
  localparam logic [POS_W-1:0]  POS_HDR_LAST  = 14'd3;
  localparam logic [POS_W-1:0]  HEADER_BYTES  = 14'd4;
  localparam logic [POS_W:0]    FRAME_OVHD    = 15'd8;
  localparam logic [SUM_W-1:0]  SUM_GOOD      = 16'hFFFF;

  typedef struct packed {
    logic [BYTE_W-1:0] start_byte;
    logic [BYTE_W-1:0] device_address;
  } cfg_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BODY_W-1:0]   body_bytes;
    logic [POS_W-1:0]    byte_position;
    logic [BYTE_W-1:0]   byte_out;
  } result_t;

  // 16-bit ones-complement add with end-around carry
  function automatic logic [SUM_W-1:0] ones_add(input logic [SUM_W-1:0] acc,
                                                input logic [SUM_W-1:0] word);
    logic [SUM_W:0] s;
    s = {1'b0, acc} + {1'b0, word};
    return s[SUM_W-1:0] + {{(SUM_W-1){1'b0}}, s[SUM_W]};
  endfunction

endpackage

>>> hdl/cfbr_cfg_regs.sv
// ----------------------------------------------------------------------------
// cfbr_cfg_regs
// Holds the start byte and device address written over the config channel.
// ----------------------------------------------------------------------------
module cfbr_cfg_regs
  import cfbr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [BYTE_W-1:0]    wr_data,
  output cfg_t                 cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_START_BYTE:  cfg_r.start_byte     <= wr_data;
        REG_DEVICE_ADDR: cfg_r.device_address <= wr_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

>>> hdl/cfbr_track.sv
// ----------------------------------------------------------------------------
// cfbr_track
// Frame state and running checksum; forms the result for each accepted byte.
// ----------------------------------------------------------------------------
module cfbr_track
  import cfbr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [BYTE_W-1:0] rx_byte,
  input  cfg_t              cfg,
  output result_t           res
);

  logic [POS_W-1:0]  byte_count_r,  byte_count_nxt;
  logic [BODY_W-1:0] body_len_r,    body_len_nxt;
  logic              match_r,       match_nxt;
  logic [BYTE_W-1:0] len_low_r,     len_low_nxt;
  logic [BYTE_W-1:0] high_r,        high_nxt;
  logic [SUM_W-1:0]  sum_r,         sum_nxt;

  logic [POS_W:0]    pos_inc;
  logic [POS_W:0]    end_lim;
  logic [BODY_W-1:0] body_hdr;

  assign pos_inc  = {1'b0, byte_count_r} + 15'd1;
  assign end_lim  = {2'b0, body_len_r} + FRAME_OVHD;
  assign body_hdr = {rx_byte[3:0], len_low_r, 1'b0};

  always_comb begin
    sum_nxt        = sum_r;
    high_nxt       = high_r;
    match_nxt      = match_r;
    len_low_nxt    = len_low_r;
    body_len_nxt   = body_len_r;
    byte_count_nxt = pos_inc[POS_W-1:0];

    res.byte_out      = rx_byte;
    res.byte_position = byte_count_r;
    res.body_bytes    = body_len_r;
    res.status        = ST_IN_FRAME;

    // even position opens a big-endian word, odd position closes it
    if (!byte_count_r[0]) begin
      if (byte_count_r == POS_FIRST) begin
        sum_nxt = '0;
      end
      high_nxt = rx_byte;
    end else begin
      sum_nxt = ones_add(sum_r, {high_r, rx_byte});
    end

    if (byte_count_r == POS_FIRST) begin
      match_nxt = (rx_byte == cfg.start_byte);
    end else if (byte_count_r == POS_ADDR) begin
      match_nxt = match_r && (rx_byte == cfg.device_address);
    end else if (byte_count_r == POS_LEN_LOW) begin
      len_low_nxt = rx_byte;
    end

    priority if (byte_count_r == POS_HDR_LAST) begin
      if (match_r) begin
        body_len_nxt   = body_hdr;
        byte_count_nxt = HEADER_BYTES;
        res.body_bytes = body_hdr;
      end else begin
        body_len_nxt   = '0;
        byte_count_nxt = '0;
        res.body_bytes = '0;
        res.status     = ST_REJECTED;
      end
    end else if (byte_count_r >= HEADER_BYTES && pos_inc >= end_lim) begin
      res.status     = (sum_nxt == SUM_GOOD) ? ST_GOOD : ST_BAD;
      body_len_nxt   = '0;
      byte_count_nxt = '0;
    end else begin
      // keep counting through the frame
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      body_len_r   <= '0;
      match_r      <= 1'b0;
      len_low_r    <= '0;
      high_r       <= '0;
      sum_r        <= '0;
    end else if (accept) begin
      byte_count_r <= byte_count_nxt;
      body_len_r   <= body_len_nxt;
      match_r      <= match_nxt;
      len_low_r    <= len_low_nxt;
      high_r       <= high_nxt;
      sum_r        <= sum_nxt;
    end
  end

endmodule

>>> hdl/cfbr_out_stage.sv
// ----------------------------------------------------------------------------
// cfbr_out_stage
// Result register of the output channel; frees itself in the cycle it drains.
// ----------------------------------------------------------------------------
module cfbr_out_stage
  import cfbr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  result_t               res,
  output logic                  can_load,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  logic    valid_r;
  result_t data_r;

  assign can_load = !valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  // payload holds while stalled
  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {{(OUT_DATA_W - RES_BITS){1'b0}}, data_r};

endmodule

>>> hdl/checked_frame_byte_receiver.sv
// ----------------------------------------------------------------------------
// checked_frame_byte_receiver
// Delimits frames in a received byte stream, checks the header and the
// ones-complement checksum, and tags every byte with its frame status.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake            | Payload
//  in_     | slave     | in_tvalid/in_tready  | in_tdata: rx_byte
//  out_    | master    | out_tvalid/out_tready| out_tdata: byte, position, body, status
//  cfg_    | slave     | cfg_valid/cfg_ready  | cfg_index, cfg_wdata
//
//  One byte per cycle unless the output stalls; a result appears in the cycle after its input transfer.
//  The single checksum accumulator is updated on each accepted byte.
//  in_tready drops only while the result register is full and not drained.
//  Reset (synchronous, rst_n low) clears frame state, config registers and out_tvalid.
//  cfg_ready is always high.
// ----------------------------------------------------------------------------
module checked_frame_byte_receiver
  import cfbr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [BYTE_W-1:0]     in_tdata,   // [7:0] rx_byte
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [7:0] byte_out, [21:8] byte_position, [34:22] body_bytes, [36:35] status
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [BYTE_W-1:0]     cfg_wdata
);

  cfg_t    cfg;
  result_t res;
  logic    can_load;
  logic    in_xfer;

  assign cfg_ready = 1'b1;
  assign in_tready = can_load;
  assign in_xfer   = in_tvalid && can_load;

  cfbr_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_wdata),
    .cfg      (cfg)
  );

  cfbr_track u_track (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_xfer),
    .rx_byte (in_tdata),
    .cfg     (cfg),
    .res     (res)
  );

  cfbr_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (in_xfer),
    .res        (res),
    .can_load   (can_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

>>> hdl/cfbr_checker.sv
// ----------------------------------------------------------------------------
// cfbr_checker
// Port-level checks of the frame byte receiver, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cfbr_checker
  import cfbr_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  logic [POS_W-1:0]    o_pos;
  logic [BODY_W-1:0]   o_body;
  logic [STATUS_W-1:0] o_status;
  logic                out_stall;
  logic                o_reject;
  logic                o_end;
  logic [POS_W:0]      end_pos;

  assign o_pos    = out_tdata[BODY_LSB-1:POS_LSB];
  assign o_body   = out_tdata[STATUS_LSB-1:BODY_LSB];
  assign o_status = out_tdata[RES_BITS-1:STATUS_LSB];

  assign out_stall = out_tvalid && !out_tready;
  assign o_reject  = out_tvalid && (o_status == ST_REJECTED);
  assign o_end     = out_tvalid && (o_status == ST_GOOD || o_status == ST_BAD);
  assign end_pos   = {2'b0, o_body} + FRAME_OVHD - 15'd1;

  `CFBR_ASSERT_ALWAYS(a_rst_clears_out, !rst_n |=> !out_tvalid, "out_tvalid after reset")
  `CFBR_ASSERT(a_hold_stalled, out_stall |=> out_tvalid && $stable(out_tdata), "held result moved")
  `CFBR_ASSERT(a_ready_when_empty, !out_tvalid |-> in_tready, "input blocked with empty output")
  `CFBR_ASSERT(a_reject_shape, o_reject |-> o_pos == POS_HDR_LAST && o_body == '0, "bad reject")
  `CFBR_ASSERT(a_end_position, o_end |-> {1'b0, o_pos} == end_pos, "frame end at wrong position")

endmodule

bind checked_frame_byte_receiver cfbr_checker u_cfbr_checker (.*);
